// ----- rtl/core/sbox_pkg.sv -----
package sbox_pkg;

  // Coordinate format: signed Q16.16
  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SIZE_BITS   = COORD_BITS - 1;
  localparam int MARGIN_BITS = 16;

  // Doubled line radius b - a, signed
  localparam int LEN_BITS  = COORD_BITS + 1;
  // Doubled center distance a + b - 2*min - size, signed
  localparam int DIST_BITS = COORD_BITS + 3;
  // Unsigned width for the box-axis compare
  localparam int MAG_BITS  = COORD_BITS + 2;
  // Cross-test products
  localparam int PROD_BITS = LEN_BITS + DIST_BITS;
  localparam int RPRD_BITS = SIZE_BITS + LEN_BITS;
  localparam int CMP_BITS  = PROD_BITS + 1;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE_Z = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_CROSS_MARGIN = 3'd6;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd1;

  // Box-axis stage result
  typedef struct packed {
    logic [2:0][LEN_BITS-1:0]  len;
    logic [2:0][DIST_BITS-1:0] cdist;
    logic                      sep;
  } axis_t;

  // Cross-test products, one entry per axis pair
  typedef struct packed {
    logic [2:0][PROD_BITS-1:0] lhs_p;
    logic [2:0][PROD_BITS-1:0] lhs_q;
    logic [2:0][RPRD_BITS-1:0] rhs_p;
    logic [2:0][RPRD_BITS-1:0] rhs_q;
    logic                      sep;
  } prod_t;

endpackage

// ----- rtl/core/sbox_seg_if.sv -----
interface sbox_seg_if;
  import sbox_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_a_x;
  logic signed [COORD_BITS-1:0] seg_a_y;
  logic signed [COORD_BITS-1:0] seg_a_z;
  logic signed [COORD_BITS-1:0] seg_b_x;
  logic signed [COORD_BITS-1:0] seg_b_y;
  logic signed [COORD_BITS-1:0] seg_b_z;

  modport source (
    output valid, seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z,
    input  ready
  );
  modport sink (
    input  valid, seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z,
    output ready
  );
endinterface

// ----- rtl/core/sbox_res_if.sv -----
interface sbox_res_if;
  logic valid;
  logic ready;
  logic overlaps;

  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

// ----- rtl/core/sbox_cfg_if.sv -----
interface sbox_cfg_if;
  import sbox_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] value;

  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

// ----- rtl/core/sbox_axis.sv -----
// Box-axis tests: doubled radius and center distance per axis
module sbox_axis import sbox_pkg::*; (
  input  logic [2:0][COORD_BITS-1:0] seg_a_i,
  input  logic [2:0][COORD_BITS-1:0] seg_b_i,
  input  logic [2:0][COORD_BITS-1:0] box_min_i,
  input  logic [2:0][SIZE_BITS-1:0]  box_size_i,
  output axis_t                      axis_o
);

  logic signed [LEN_BITS-1:0]  len  [3];
  logic signed [DIST_BITS-1:0] cdist [3];
  logic [LEN_BITS-1:0]         len_mag [3];
  logic [MAG_BITS-1:0]         dist_mag [3];
  logic [2:0]                  sep;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    always_comb begin
      len[k]  = LEN_BITS'($signed(seg_b_i[k])) - LEN_BITS'($signed(seg_a_i[k]));
      cdist[k] = DIST_BITS'($signed(seg_a_i[k])) + DIST_BITS'($signed(seg_b_i[k]))
               - (DIST_BITS'($signed(box_min_i[k])) <<< 1)
               - $signed(DIST_BITS'(box_size_i[k]));
      len_mag[k]  = len[k][LEN_BITS-1] ? LEN_BITS'(-len[k]) : LEN_BITS'(len[k]);
      dist_mag[k] = cdist[k][DIST_BITS-1] ? MAG_BITS'(-cdist[k]) : MAG_BITS'(cdist[k]);
      // strict compare: touching counts as overlap
      sep[k] = dist_mag[k] > (MAG_BITS'(box_size_i[k]) + MAG_BITS'(len_mag[k]));
    end
    assign axis_o.len[k]   = len[k];
    assign axis_o.cdist[k] = cdist[k];
  end

  assign axis_o.sep = |sep;

endmodule

// ----- rtl/core/sbox_prod.sv -----
// Cross-axis products for the pairs (y,z), (z,x), (x,y)
module sbox_prod import sbox_pkg::*; (
  input  axis_t                     axis_i,
  input  logic [2:0][SIZE_BITS-1:0] box_size_i,
  output prod_t                     prod_o
);

  for (genvar p = 0; p < 3; p++) begin : g_pair
    localparam int I = (p + 1) % 3;
    localparam int J = (p + 2) % 3;

    logic signed [LEN_BITS-1:0]  len_i;
    logic signed [LEN_BITS-1:0]  len_j;
    logic signed [DIST_BITS-1:0] dist_i;
    logic signed [DIST_BITS-1:0] dist_j;
    logic [LEN_BITS-1:0]         mag_i;
    logic [LEN_BITS-1:0]         mag_j;
    logic signed [PROD_BITS-1:0] lhs_p;
    logic signed [PROD_BITS-1:0] lhs_q;

    always_comb begin
      len_i  = $signed(axis_i.len[I]);
      len_j  = $signed(axis_i.len[J]);
      dist_i = $signed(axis_i.cdist[I]);
      dist_j = $signed(axis_i.cdist[J]);
      mag_i  = len_i[LEN_BITS-1] ? LEN_BITS'(-len_i) : LEN_BITS'(len_i);
      mag_j  = len_j[LEN_BITS-1] ? LEN_BITS'(-len_j) : LEN_BITS'(len_j);
      // li*dj and lj*di, full width signed
      lhs_p  = PROD_BITS'(len_i) * PROD_BITS'(dist_j);
      lhs_q  = PROD_BITS'(len_j) * PROD_BITS'(dist_i);
    end

    assign prod_o.lhs_p[p] = lhs_p;
    assign prod_o.lhs_q[p] = lhs_q;
    // si*|lj| and sj*|li|, unsigned
    assign prod_o.rhs_p[p] = RPRD_BITS'(box_size_i[I]) * RPRD_BITS'(mag_j);
    assign prod_o.rhs_q[p] = RPRD_BITS'(box_size_i[J]) * RPRD_BITS'(mag_i);
  end

  assign prod_o.sep = axis_i.sep;

endmodule

// ----- rtl/core/sbox_cmp.sv -----
// Cross-axis compares with margin, final overlap decision
module sbox_cmp import sbox_pkg::*; (
  input  prod_t                  prod_i,
  input  logic [MARGIN_BITS-1:0] margin_i,
  output logic                   overlaps_o
);

  logic signed [CMP_BITS-1:0] eps;
  logic [2:0]                 sep;

  // margin scaled to the product format (doubled halves, 2*FRAC_BITS)
  assign eps = $signed(CMP_BITS'(margin_i) << (FRAC_BITS + 2));

  for (genvar p = 0; p < 3; p++) begin : g_cmp
    logic signed [CMP_BITS-1:0] diff;
    logic signed [CMP_BITS-1:0] rhs;
    logic signed [CMP_BITS-1:0] low;

    always_comb begin
      diff = CMP_BITS'($signed(prod_i.lhs_p[p])) - CMP_BITS'($signed(prod_i.lhs_q[p]));
      rhs  = $signed(CMP_BITS'(prod_i.rhs_p[p])) + $signed(CMP_BITS'(prod_i.rhs_q[p])) + eps;
      // |diff| > rhs  <=>  diff > rhs or diff + rhs < 0
      low  = diff + rhs;
      sep[p] = (diff > rhs) || low[CMP_BITS-1];
    end
  end

  assign overlaps_o = !(prod_i.sep || (|sep));

endmodule

// ----- rtl/core/segment_box_overlap_test.sv -----
// Segment versus axis-aligned box overlap test (separating axis test).
// seg_i: one beat carries both 3-D endpoints of a segment, signed Q16.16.
// res_o: one beat per segment, overlaps = 1 unless a separating axis exists.
// cfg_i: register writes (box corner, box size, cross margin); always ready.
//   Write only while no segment is in flight.
// Pipeline: input register, box-axis stage, product stage, output register.
// Throughput is one segment per cycle while res_o.ready stays high.
// Each stage holds one segment and moves on when the stage after it is empty
// or moving, so bubbles close up.
// When the receiver stalls, the pipeline keeps taking segments until all
// four stages are full, then seg_i.ready drops; nothing is dropped.
// Reset clears all stage valid flags and sets the box registers to zero and
// the cross margin to one.
module segment_box_overlap_test import sbox_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sbox_seg_if.sink          seg_i,
  sbox_res_if.source        res_o,
  sbox_cfg_if.sink          cfg_i
);

  // Configuration registers
  logic [2:0][COORD_BITS-1:0] box_min_q;
  logic [2:0][SIZE_BITS-1:0]  box_size_q;
  logic [MARGIN_BITS-1:0]     margin_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q  <= '0;
      box_size_q <= '0;
      margin_q   <= MARGIN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BOX_MIN_X:    box_min_q[0]  <= cfg_i.value[COORD_BITS-1:0];
        REG_BOX_MIN_Y:    box_min_q[1]  <= cfg_i.value[COORD_BITS-1:0];
        REG_BOX_MIN_Z:    box_min_q[2]  <= cfg_i.value[COORD_BITS-1:0];
        REG_BOX_SIZE_X:   box_size_q[0] <= cfg_i.value[SIZE_BITS-1:0];
        REG_BOX_SIZE_Y:   box_size_q[1] <= cfg_i.value[SIZE_BITS-1:0];
        REG_BOX_SIZE_Z:   box_size_q[2] <= cfg_i.value[SIZE_BITS-1:0];
        REG_CROSS_MARGIN: margin_q      <= cfg_i.value[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid flags and advance enables
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  assign eno = !vo_q || res_o.ready;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign seg_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= seg_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // Input register
  logic [2:0][COORD_BITS-1:0] seg_a_q, seg_b_q;

  always_ff @(posedge clk_i) begin
    if (en1 && seg_i.valid) begin
      seg_a_q <= {seg_i.seg_a_z, seg_i.seg_a_y, seg_i.seg_a_x};
      seg_b_q <= {seg_i.seg_b_z, seg_i.seg_b_y, seg_i.seg_b_x};
    end
  end

  // Box-axis stage
  axis_t axis_d, axis_q;

  sbox_axis u_axis (
    .seg_a_i    (seg_a_q),
    .seg_b_i    (seg_b_q),
    .box_min_i  (box_min_q),
    .box_size_i (box_size_q),
    .axis_o     (axis_d)
  );

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) axis_q <= axis_d;
  end

  // Product stage
  prod_t prod_d, prod_q;

  sbox_prod u_prod (
    .axis_i     (axis_q),
    .box_size_i (box_size_q),
    .prod_o     (prod_d)
  );

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) prod_q <= prod_d;
  end

  // Compare and output register
  logic overlaps_d, overlaps_q;

  sbox_cmp u_cmp (
    .prod_i     (prod_q),
    .margin_i   (margin_q),
    .overlaps_o (overlaps_d)
  );

  always_ff @(posedge clk_i) begin
    if (eno && v3_q) overlaps_q <= overlaps_d;
  end

  assign res_o.valid    = vo_q;
  assign res_o.overlaps = overlaps_q;

`ifndef SYNTHESIS
  // input back-pressure only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seg_i.ready |-> (v1_q && v2_q && v3_q && vo_q && !res_o.ready))
    else $error("input stalled with room in the pipeline");

  // an accepted beat lands in the input register
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_i.valid && seg_i.ready) |=> v1_q)
    else $error("accepted segment not captured");

  // a finished product stage moves to the output when the slot is free
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && eno) |=> res_o.valid)
    else $error("result lost between product stage and output");

  // a blocked axis stage keeps its segment
  a_axis_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && $stable(axis_q)))
    else $error("axis stage changed while blocked");
`endif

endmodule

// ----- dv/sbox_overlap_monitor.sv -----
// Watches the segment, result and register channels of the overlap block,
// predicts each segment's overlap flag and compares it with the result beats.
module sbox_overlap_monitor import sbox_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbox_seg_if         seg_i,
  sbox_res_if         res_i,
  sbox_cfg_if         cfg_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Cross-axis products need about 70 bits; keep headroom.
  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic        overlaps;
    int unsigned id;
  } overlap_pred_t;

  // Local copy of the box registers
  logic signed [COORD_BITS-1:0] box_min [3];
  logic [SIZE_BITS-1:0]         box_size [3];
  logic [MARGIN_BITS-1:0]       margin;

  overlap_pred_t                expected_overlaps [$];
  overlap_pred_t                oldest;
  logic signed [COORD_BITS-1:0] ends_a [3];
  logic signed [COORD_BITS-1:0] ends_b [3];
  int unsigned                  segments_seen;
  int unsigned                  results_seen;
  int unsigned                  mismatches;
  int unsigned                  pending;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // One cross-product axis: |li*dj - lj*di| against si*|lj| + sj*|li| + margin
  function automatic bit cross_separates(input longint li, input longint lj,
                                         input longint di, input longint dj,
                                         input longint si, input longint sj);
    wide_t lhs;
    wide_t rhs;
    lhs = wide_t'(li) * wide_t'(dj) - wide_t'(lj) * wide_t'(di);
    if (lhs < 0) lhs = -lhs;
    rhs = wide_t'(si) * wide_t'(magnitude(lj)) + wide_t'(sj) * wide_t'(magnitude(li))
        + wide_t'(longint'(margin) << (FRAC_BITS + 2));
    return lhs > rhs;
  endfunction

  // Doubled half-extents keep everything exact; touching is not separation.
  function automatic logic predict_overlap(input logic signed [COORD_BITS-1:0] a [3],
                                           input logic signed [COORD_BITS-1:0] b [3]);
    longint len [3];
    longint cdist [3];
    longint ext [3];
    bit     sep;
    sep = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ext[k]   = longint'(box_size[k]);
      len[k]   = longint'(b[k]) - longint'(a[k]);
      cdist[k] = longint'(a[k]) + longint'(b[k]) - 2 * longint'(box_min[k]) - ext[k];
      if (magnitude(cdist[k]) > ext[k] + magnitude(len[k])) sep = 1'b1;
    end
    if (!sep) sep = cross_separates(len[1], len[2], cdist[1], cdist[2], ext[1], ext[2]);
    if (!sep) sep = cross_separates(len[2], len[0], cdist[2], cdist[0], ext[2], ext[0]);
    if (!sep) sep = cross_separates(len[0], len[1], cdist[0], cdist[1], ext[0], ext[1]);
    return !sep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min  = '{default: '0};
      box_size = '{default: '0};
      margin   = MARGIN_RESET;
      expected_overlaps.delete();
      pending  = 0;
    end else begin
      // result beat against the oldest prediction
      if (res_i.valid && res_i.ready) begin
        results_seen++;
        if (expected_overlaps.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no segment pending", results_seen));
        end else begin
          oldest = expected_overlaps.pop_front();
          if (res_i.overlaps !== oldest.overlaps)
            report_mismatch($sformatf("segment %0d: overlaps got %b want %b",
                                      oldest.id, res_i.overlaps, oldest.overlaps));
        end
      end
      // segment beat: predict with the current box
      if (seg_i.valid && seg_i.ready) begin
        ends_a = '{seg_i.seg_a_x, seg_i.seg_a_y, seg_i.seg_a_z};
        ends_b = '{seg_i.seg_b_x, seg_i.seg_b_y, seg_i.seg_b_z};
        expected_overlaps.push_back('{overlaps: predict_overlap(ends_a, ends_b),
                                      id: segments_seen});
        segments_seen++;
      end
      // register write; unknown indexes are dropped, upper bits masked
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_BOX_MIN_X:    box_min[0]  = cfg_i.value[COORD_BITS-1:0];
          REG_BOX_MIN_Y:    box_min[1]  = cfg_i.value[COORD_BITS-1:0];
          REG_BOX_MIN_Z:    box_min[2]  = cfg_i.value[COORD_BITS-1:0];
          REG_BOX_SIZE_X:   box_size[0] = cfg_i.value[SIZE_BITS-1:0];
          REG_BOX_SIZE_Y:   box_size[1] = cfg_i.value[SIZE_BITS-1:0];
          REG_BOX_SIZE_Z:   box_size[2] = cfg_i.value[SIZE_BITS-1:0];
          REG_CROSS_MARGIN: margin      = cfg_i.value[MARGIN_BITS-1:0];
          default: ;
        endcase
      end
      pending = expected_overlaps.size();
    end
  end

endmodule

// ----- dv/segment_box_overlap_test_test.sv -----
module segment_box_overlap_test_test import sbox_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_ITEMS     = 205;
  localparam int unsigned RES_HOLD_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int          ONE             = 1 << FRAC_BITS;

  // Index past the register list; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0]  REG_UNUSED = 3'd7;
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [SIZE_BITS-1:0]         S_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;

  sbox_seg_if seg_if ();
  sbox_res_if res_if ();
  sbox_cfg_if cfg_if ();

  int unsigned mismatch_total;
  int unsigned in_flight;
  int unsigned cycles = 0;

  // Box as last written, used to aim segments at it
  longint box_lo [3]  = '{0, 0, 0};
  longint box_ext [3] = '{0, 0, 0};

  bit          idle_on    = 1'b1;
  bit          hold_res   = 1'b0;
  int unsigned burst_left = 0;

  segment_box_overlap_test dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seg_i  (seg_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  sbox_overlap_monitor monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .seg_i        (seg_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .mismatches_o (mismatch_total),
    .pending_o    (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.value <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_box(input logic signed [COORD_BITS-1:0] mx, my, mz,
                         input logic [CFG_DATA_BITS-1:0] sx, sy, sz, eps);
    write_reg(REG_BOX_MIN_X, mx);
    write_reg(REG_BOX_MIN_Y, my);
    write_reg(REG_BOX_MIN_Z, mz);
    write_reg(REG_BOX_SIZE_X, sx);
    write_reg(REG_BOX_SIZE_Y, sy);
    write_reg(REG_BOX_SIZE_Z, sz);
    write_reg(REG_CROSS_MARGIN, eps);
    box_lo  = '{longint'(mx), longint'(my), longint'(mz)};
    box_ext = '{longint'(sx[SIZE_BITS-1:0]), longint'(sy[SIZE_BITS-1:0]),
                longint'(sz[SIZE_BITS-1:0])};
  endtask

  // One segment beat, after a random gap unless a burst is running or idle_on is clear
  task automatic send_segment(input logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz);
    int unsigned gap;
    gap = (burst_left > 0 || !idle_on) ? 0 : $urandom_range(0, 3);
    if (burst_left > 0) burst_left--;
    repeat (gap) begin
      @(negedge clk);
      seg_if.valid <= 1'b0;
    end
    @(negedge clk);
    seg_if.valid   <= 1'b1;
    seg_if.seg_a_x <= ax;
    seg_if.seg_a_y <= ay;
    seg_if.seg_a_z <= az;
    seg_if.seg_b_x <= bx;
    seg_if.seg_b_y <= by;
    seg_if.seg_b_z <= bz;
    do @(posedge clk); while (!seg_if.ready);
  endtask

  // Stop offering segments and let every result come back
  task automatic drain();
    @(negedge clk);
    seg_if.valid <= 1'b0;
    wait (in_flight == 0);
  endtask

  // Coordinate on, just past, or around the box faces, or anywhere
  function automatic logic signed [COORD_BITS-1:0] near_box(input int axis);
    longint lo;
    longint hi;
    longint span;
    longint v;
    lo   = box_lo[axis];
    hi   = lo + box_ext[axis];
    span = box_ext[axis] + 1;
    case ($urandom_range(0, 7))
      0: v = lo;
      1: v = hi;
      2, 3: v = lo + longint'($urandom) % span;
      4: v = lo - longint'($urandom_range(1, 4));
      5: v = hi + longint'($urandom_range(1, 4));
      6: v = lo - span + longint'($urandom) % (3 * span);
      default: v = longint'($signed($urandom));
    endcase
    if (v < longint'(C_MIN)) v = longint'(C_MIN);
    if (v > longint'(C_MAX)) v = longint'(C_MAX);
    return v[COORD_BITS-1:0];
  endfunction

  task automatic send_random_segment();
    logic signed [COORD_BITS-1:0] a [3];
    logic signed [COORD_BITS-1:0] b [3];
    int unsigned kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      a[k] = near_box(k);
      case (kind)
        0: b[k] = a[k];                      // point segment
        1: b[k] = $urandom;                  // one wild end
        2: begin a[k] = $urandom; b[k] = $urandom; end
        default: b[k] = near_box(k);
      endcase
    end
    send_segment(a[0], a[1], a[2], b[0], b[1], b[2]);
  endtask

  // style: 0 mid-size near origin, 1 full range, 2 tiny or flat, 3 extremes
  task automatic random_box(input int unsigned style);
    logic signed [COORD_BITS-1:0] lo [3];
    logic [CFG_DATA_BITS-1:0]     ext [3];
    logic [CFG_DATA_BITS-1:0]     eps;
    for (int k = 0; k < 3; k++) begin
      case (style)
        0: begin
          lo[k]  = $urandom_range(0, 8 * ONE) - 4 * ONE;
          ext[k] = $urandom_range(0, 4 * ONE);
        end
        1: begin
          lo[k]  = $urandom;
          ext[k] = $urandom;                 // top bit gets masked
        end
        2: begin
          lo[k]  = $urandom_range(0, 64) - 32;
          ext[k] = $urandom_range(0, 3);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: lo[k] = C_MIN;
            1: lo[k] = C_MAX;
            default: lo[k] = '0;
          endcase
          ext[k] = $urandom_range(0, 1) ? {1'b0, S_MAX} : '0;
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0: eps = '0;
      1: eps = 32'h0000_FFFF;
      2: eps = $urandom_range(0, 16);
      default: eps = $urandom;
    endcase
    set_box(lo[0], lo[1], lo[2], ext[0], ext[1], ext[2], eps);
  endtask

  // Result side: random stall per beat, plus one long hold on request
  initial begin : result_side
    int unsigned stall;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_res) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
        repeat (RES_HOLD_CYCLES) @(negedge clk);
        hold_res = 1'b0;
        res_if.ready <= 1'b1;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
        repeat (stall) begin
          @(negedge clk);
          res_if.ready <= 1'b0;
        end
        @(negedge clk);
        res_if.ready <= 1'b1;
      end
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
    end
  end

  initial begin
    seg_if.valid   = 1'b0;
    seg_if.seg_a_x = '0;
    seg_if.seg_a_y = '0;
    seg_if.seg_a_z = '0;
    seg_if.seg_b_x = '0;
    seg_if.seg_b_y = '0;
    seg_if.seg_b_z = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.value   = '0;
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset box: a point at the origin, margin of one
    send_segment(0, 0, 0, 0, 0, 0);
    send_segment(-ONE, 0, 0, ONE, 0, 0);
    send_segment(ONE, ONE, 0, ONE, 2 * ONE, 0);
    drain();

    // box [-2, 2] on every axis
    set_box(-2 * ONE, -2 * ONE, -2 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 1);
    send_segment(0, 0, 0, ONE, ONE, ONE);
    send_segment(10 * ONE, 10 * ONE, 10 * ONE, 11 * ONE, 11 * ONE, 11 * ONE);
    // touching a face, then one step past it
    send_segment(2 * ONE, 0, 0, 3 * ONE, 0, 0);
    send_segment(2 * ONE + 1, 0, 0, 3 * ONE, 0, 0);
    // point segments inside and outside
    send_segment(ONE, -ONE, 0, ONE, -ONE, 0);
    send_segment(3 * ONE, 0, 0, 3 * ONE, 0, 0);
    // diagonal grazing the corner edge, then missing it (cross axis only)
    send_segment(5 * ONE, -ONE, 0, -ONE, 5 * ONE, 0);
    send_segment(6 * ONE, -ONE, 0, -ONE, 6 * ONE, 0);
    send_segment(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_segment(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    drain();

    // largest box from the lowest corner, widest margin
    set_box(C_MIN, C_MIN, C_MIN, S_MAX, S_MAX, S_MAX, 32'h0000_FFFF);
    send_segment(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_segment(C_MIN, C_MAX, 0, C_MAX, C_MIN, 0);
    drain();

    // dropped write, then box at the top corner with junk upper bits, no margin
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    set_box(C_MAX, C_MAX, C_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_0000);
    send_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_segment(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
    send_segment(C_MAX - 1, C_MAX, C_MAX, C_MAX - 1, C_MAX, C_MAX);
    drain();

    // random phases, each with a fresh box
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      random_box(phase % 4);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // long result hold while segments keep coming back to back
        if (phase == 2 && i == 40) begin
          hold_res   = 1'b1;
          burst_left = 24;
        end
        if (phase == 5 && i == 100) drain();
        send_random_segment();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
